// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/adsr_pkg.sv =====
`default_nettype none
package adsr_pkg;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_ATTACK      = 4'd1,
		PH_HOLD        = 4'd2,
		PH_PREDECAY    = 4'd3,
		PH_DECAY       = 4'd4,
		PH_POSTDECAY   = 4'd5,
		PH_PRERELEASE  = 4'd6,
		PH_RELEASE     = 4'd7,
		PH_POSTRELEASE = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		NOTE_OFF = 2'd0,
		NOTE_ON  = 2'd1,
		NOTE_NEW = 2'd2
	} note_t;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;

	typedef enum logic [1:0] {
		CURVE_ATTACK  = 2'd0,
		CURVE_DECAY   = 2'd1,
		CURVE_RELEASE = 2'd2
	} curve_kind_t;

	typedef struct packed {
		logic [7:0]        attack_setting;
		logic signed [7:0] attack_power;
		logic [7:0]        decay_setting;
		logic signed [7:0] decay_power;
		logic [7:0]        sustain_level;
		logic [7:0]        release_setting;
		logic signed [7:0] release_power;
		logic [7:0]        hold_setting;
	} adsr_cfg_t;

	typedef struct packed {
		logic        start;
		curve_kind_t kind;
		logic [15:0] t;
	} curve_cmd_t;

	typedef struct packed {
		logic       done;
		logic [7:0] value;
	} curve_sts_t;

	localparam int unsigned ROOT_COUNT = 12;

	// 2^(2^-(k+1)) in Q30
	localparam logic [30:0] ROOT_Q30 [ROOT_COUNT] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
		31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544
	};

endpackage
`default_nettype wire

// ===== hw/rtl/adsr_in_if.sv =====
`default_nettype none
interface adsr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] elapsed_ms;

	modport source (output valid, output operation, output elapsed_ms, input ready);
	modport sink (input valid, input operation, input elapsed_ms, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/adsr_out_if.sv =====
`default_nettype none
interface adsr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] amplitude;
	logic [3:0] phase;

	modport source (output valid, output amplitude, output phase, input ready);
	modport sink (input valid, input amplitude, input phase, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/adsr_curve.sv =====
`default_nettype none
module adsr_curve
	import adsr_pkg::*;
#(
	parameter int unsigned TBITS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire adsr_cfg_t  cfg,
	input  wire curve_cmd_t cmd,
	output curve_sts_t      sts
);

	localparam int unsigned LW = TBITS + 5;
	localparam int unsigned YW = TBITS + 9;
	localparam int unsigned EW = 34;
	localparam int unsigned PW = EW + LW;
	localparam logic [3:0] DIV_LAST = 4'd15;
	localparam logic [3:0] F_LAST = 4'(TBITS - 1);

	typedef enum logic [3:0] {
		C_IDLE, C_PREP, C_SETUP, C_CHECK, C_DIV, C_NORM, C_SQ, C_EXPA,
		C_MUL, C_YCHK, C_EXPB, C_PROD, C_SCALE, C_FIN
	} cstate_t;

	cstate_t           state_q;
	curve_kind_t       kind_q;
	logic [15:0]       t_q;
	logic [12:0]       tlen_q;
	logic [15:0]       tt_q;
	logic [7:0]        amax_q;
	logic [7:0]        off_q;
	logic signed [7:0] pw_q;
	logic [18:0]       xu_q;
	logic [12:0]       rem_q;
	logic [15:0]       mm_q;
	logic [3:0]        sh_q;
	logic [TBITS-1:0]  frac_q;
	logic [TBITS-1:0]  g_q;
	logic [31:0]       m_q;
	logic [YW-1:0]     y_q;
	logic [39:0]       prod_q;
	logic [7:0]        c_q;
	logic [3:0]        cnt_q;
	curve_sts_t        sts_q;

	logic [7:0]  setting;
	logic [17:0] t1000;
	logic [20:0] t5000;
	logic [12:0] tlen_d;
	logic [15:0] tt_d;
	logic signed [19:0] xs;
	logic [13:0] div_sh;
	logic [13:0] div_nx;
	logic        div_ge;
	logic [31:0] sq;
	logic [16:0] sq_sh;
	logic [30:0] root;
	logic [62:0] exp_prod;
	logic [31:0] m_nx;
	logic [LW-1:0] lval;
	logic [2:0]  nh;
	logic [EW-1:0] e;
	logic [PW-1:0] yprod;
	logic [8:0]  yi;
	logic [TBITS-1:0] yf;
	logic [39:0] sc;
	logic [8:0]  fsum;

	always_comb begin
		case (kind_q)
			CURVE_ATTACK: setting = cfg.attack_setting;
			CURVE_DECAY: setting = cfg.decay_setting;
			default: setting = cfg.release_setting;
		endcase
		t1000 = 18'(setting) * 18'd1000;
		t5000 = 21'(setting) * 21'd5000;
		tlen_d = (kind_q == CURVE_RELEASE) ? t5000[20:8] : {3'b000, t1000[17:8]};
		if (kind_q == CURVE_ATTACK) begin
			tt_d = t_q;
		end else if (t_q < 16'(tlen_q)) begin
			tt_d = 16'(tlen_q) - t_q;
		end else begin
			tt_d = 16'd0;
		end
		xs = 20'(pw_q) * 20'sd1489 + 20'sd196608;
		div_sh = {rem_q, 1'b0};
		div_ge = div_sh >= {1'b0, tlen_q};
		div_nx = div_ge ? div_sh - {1'b0, tlen_q} : div_sh;
		sq = 32'(mm_q) * 32'(mm_q);
		sq_sh = sq[31:15];
		root = ROOT_Q30[cnt_q];
		exp_prod = 63'(m_q) * 63'(root);
		m_nx = g_q[TBITS-1] ? exp_prod[61:30] : m_q;
		lval = ((LW'(sh_q) + LW'(1)) << TBITS) - LW'(frac_q);
		nh = xu_q[18:16];
		if (nh >= 3'd3) begin
			e = EW'(m_q) << (nh - 3'd3);
		end else begin
			e = EW'(m_q) >> (3'd3 - nh);
		end
		yprod = PW'(e) * PW'(lval);
		yi = y_q[YW-1:TBITS];
		yf = y_q[TBITS-1:0];
		sc = prod_q >> (6'd31 + 6'(yi[2:0]));
		fsum = 9'(c_q) + 9'(off_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			sts_q <= '0;
		end else begin
			sts_q.done <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (cmd.start) begin
						kind_q <= cmd.kind;
						t_q <= cmd.t;
						state_q <= C_PREP;
					end
				end
				C_PREP: begin
					tlen_q <= tlen_d;
					case (kind_q)
						CURVE_ATTACK: begin
							pw_q <= cfg.attack_power;
							amax_q <= 8'd255;
							off_q <= 8'd0;
						end
						CURVE_DECAY: begin
							pw_q <= cfg.decay_power;
							amax_q <= 8'd255 - cfg.sustain_level;
							off_q <= cfg.sustain_level;
						end
						default: begin
							pw_q <= cfg.release_power;
							amax_q <= cfg.sustain_level;
							off_q <= 8'd0;
						end
					endcase
					state_q <= C_SETUP;
				end
				C_SETUP: begin
					tt_q <= tt_d;
					xu_q <= xs[18:0];
					state_q <= C_CHECK;
				end
				C_CHECK: begin
					if (tlen_q == 13'd0 || tt_q >= 16'(tlen_q)) begin
						c_q <= amax_q;
						state_q <= C_FIN;
					end else if (tt_q == 16'd0) begin
						c_q <= 8'd0;
						state_q <= C_FIN;
					end else begin
						rem_q <= tt_q[12:0];
						mm_q <= 16'd0;
						cnt_q <= 4'd0;
						state_q <= C_DIV;
					end
				end
				C_DIV: begin
					// one quotient bit per cycle
					rem_q <= div_nx[12:0];
					mm_q <= {mm_q[14:0], div_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						sh_q <= 4'd0;
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					if (mm_q == 16'd0) begin
						c_q <= 8'd0;
						state_q <= C_FIN;
					end else if (!mm_q[15]) begin
						mm_q <= {mm_q[14:0], 1'b0};
						sh_q <= sh_q + 4'd1;
					end else begin
						cnt_q <= 4'd0;
						frac_q <= '0;
						state_q <= C_SQ;
					end
				end
				C_SQ: begin
					// one log2 fraction bit per squaring
					frac_q <= {frac_q[TBITS-2:0], sq_sh[16]};
					mm_q <= sq_sh[16] ? sq_sh[16:1] : sq_sh[15:0];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == F_LAST) begin
						g_q <= xu_q[15 -: TBITS];
						m_q <= 32'h4000_0000;
						cnt_q <= 4'd0;
						state_q <= C_EXPA;
					end
				end
				C_EXPA: begin
					m_q <= m_nx;
					g_q <= {g_q[TBITS-2:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == F_LAST) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					y_q <= yprod[PW-1:30];
					state_q <= C_YCHK;
				end
				C_YCHK: begin
					if (yi >= 9'd8) begin
						c_q <= 8'd0;
						state_q <= C_FIN;
					end else if (yf == '0) begin
						m_q <= 32'h8000_0000;
						state_q <= C_PROD;
					end else begin
						g_q <= TBITS'((1 << TBITS) - int'(yf));
						m_q <= 32'h4000_0000;
						cnt_q <= 4'd0;
						state_q <= C_EXPB;
					end
				end
				C_EXPB: begin
					m_q <= m_nx;
					g_q <= {g_q[TBITS-2:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == F_LAST) begin
						state_q <= C_PROD;
					end
				end
				C_PROD: begin
					prod_q <= 40'(amax_q) * 40'(m_q);
					state_q <= C_SCALE;
				end
				C_SCALE: begin
					c_q <= (|sc[39:8]) ? 8'd255 : sc[7:0];
					state_q <= C_FIN;
				end
				C_FIN: begin
					sts_q.done <= 1'b1;
					sts_q.value <= fsum[8] ? 8'd255 : fsum[7:0];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign sts = sts_q;

endmodule
`default_nettype wire

// ===== hw/rtl/adsr_ctrl.sv =====
`default_nettype none
module adsr_ctrl
	import adsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire adsr_cfg_t  cfg,
	adsr_in_if.sink         cmd,
	adsr_out_if.source      env,
	output curve_cmd_t      ccmd,
	input  wire curve_sts_t csts
);

	typedef enum logic [2:0] {
		ST_READY, ST_DISPATCH, ST_WAIT_MAIN, ST_WAIT_SHADOW, ST_APPLY, ST_PUSH
	} state_t;

	state_t      state_q;
	phase_t      phase_q;
	note_t       note_q;
	logic [7:0]  main_amp_q;
	logic [7:0]  shadow_amp_q;
	logic [15:0] main_tmr_q;
	logic [15:0] shadow_tmr_q;
	curve_cmd_t  ccmd_q;
	logic        out_valid_q;
	logic [7:0]  out_amp_q;
	logic [3:0]  out_phase_q;

	logic [12:0] hold_prod;
	logic [7:0]  sus;

	assign hold_prod = 13'(cfg.hold_setting) * 13'd25;
	assign sus = cfg.sustain_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			phase_q <= PH_IDLE;
			note_q <= NOTE_OFF;
			main_amp_q <= 8'd0;
			shadow_amp_q <= 8'd0;
			main_tmr_q <= 16'd0;
			shadow_tmr_q <= 16'd0;
			ccmd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ccmd_q.start <= 1'b0;
			if (out_valid_q && env.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_READY: begin
					if (cmd.valid) begin
						state_q <= ST_PUSH;
						case (cmd.operation)
							OP_TICK: begin
								main_tmr_q <= main_tmr_q + 16'(cmd.elapsed_ms);
								shadow_tmr_q <= shadow_tmr_q + 16'(cmd.elapsed_ms);
								state_q <= ST_DISPATCH;
							end
							OP_NOTE_ON: note_q <= NOTE_NEW;
							OP_NOTE_OFF: note_q <= NOTE_OFF;
							default: ;
						endcase
					end
				end
				ST_DISPATCH: begin
					state_q <= ST_APPLY;
					case (phase_q)
						PH_IDLE: begin
							if (note_q != NOTE_OFF) begin
								phase_q <= PH_ATTACK;
								main_tmr_q <= 16'd0;
								note_q <= NOTE_ON;
							end
							state_q <= ST_PUSH;
						end
						PH_ATTACK: begin
							if (main_amp_q == 8'd255) begin
								phase_q <= PH_HOLD;
								main_tmr_q <= 16'd0;
								state_q <= ST_PUSH;
							end else begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_ATTACK, t: main_tmr_q};
								state_q <= ST_WAIT_MAIN;
							end
						end
						PH_HOLD: begin
							if (main_tmr_q > {11'd0, hold_prod[12:8]}) begin
								phase_q <= PH_DECAY;
								main_tmr_q <= 16'd0;
							end
							state_q <= ST_PUSH;
						end
						PH_PREDECAY, PH_PRERELEASE: begin
							ccmd_q <= '{start: 1'b1, kind: CURVE_ATTACK, t: main_tmr_q};
							state_q <= ST_WAIT_MAIN;
						end
						PH_DECAY: begin
							if (main_amp_q > sus) begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_DECAY, t: main_tmr_q};
								state_q <= ST_WAIT_MAIN;
							end
						end
						PH_POSTDECAY: begin
							if (main_amp_q > sus) begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_DECAY, t: main_tmr_q};
								state_q <= ST_WAIT_MAIN;
							end else begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_ATTACK, t: shadow_tmr_q};
								state_q <= ST_WAIT_SHADOW;
							end
						end
						PH_RELEASE: begin
							if (note_q == NOTE_OFF && main_amp_q != 8'd0) begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_RELEASE, t: main_tmr_q};
								state_q <= ST_WAIT_MAIN;
							end
						end
						PH_POSTRELEASE: begin
							if (note_q == NOTE_OFF) begin
								phase_q <= PH_RELEASE;
								state_q <= ST_PUSH;
							end else if (main_amp_q != 8'd0) begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_RELEASE, t: main_tmr_q};
								state_q <= ST_WAIT_MAIN;
							end else begin
								ccmd_q <= '{start: 1'b1, kind: CURVE_ATTACK, t: shadow_tmr_q};
								state_q <= ST_WAIT_SHADOW;
							end
						end
						default: state_q <= ST_PUSH;
					endcase
				end
				ST_WAIT_MAIN: begin
					if (csts.done) begin
						main_amp_q <= csts.value;
						state_q <= ST_WAIT_SHADOW;
						case (phase_q)
							PH_PREDECAY:
								ccmd_q <= '{start: 1'b1, kind: CURVE_DECAY, t: shadow_tmr_q};
							PH_PRERELEASE:
								ccmd_q <= '{start: 1'b1, kind: CURVE_RELEASE, t: shadow_tmr_q};
							PH_POSTDECAY, PH_POSTRELEASE:
								ccmd_q <= '{start: 1'b1, kind: CURVE_ATTACK, t: shadow_tmr_q};
							default: state_q <= ST_APPLY;
						endcase
					end
				end
				ST_WAIT_SHADOW: begin
					if (csts.done) begin
						shadow_amp_q <= csts.value;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_PUSH;
					case (phase_q)
						PH_ATTACK: begin
							if (note_q == NOTE_OFF) begin
								shadow_tmr_q <= 16'd0;
								if (main_amp_q < sus) begin
									shadow_amp_q <= sus;
									phase_q <= PH_PRERELEASE;
								end else begin
									shadow_amp_q <= 8'd255;
									phase_q <= PH_PREDECAY;
								end
							end else if (note_q == NOTE_NEW) begin
								note_q <= NOTE_ON;
							end
						end
						PH_PREDECAY: begin
							// decay curve at the shadow time is what main takes over
							if (shadow_amp_q <= main_amp_q) begin
								phase_q <= PH_DECAY;
								main_tmr_q <= shadow_tmr_q;
								main_amp_q <= shadow_amp_q;
							end
						end
						PH_DECAY: begin
							if (note_q == NOTE_NEW) begin
								note_q <= NOTE_ON;
								shadow_tmr_q <= 16'd0;
								shadow_amp_q <= 8'd0;
								phase_q <= PH_POSTDECAY;
							end else if (note_q == NOTE_OFF && main_amp_q <= sus) begin
								main_tmr_q <= 16'd0;
								phase_q <= PH_RELEASE;
							end
						end
						PH_POSTDECAY, PH_POSTRELEASE: begin
							if (shadow_amp_q > main_amp_q) begin
								phase_q <= PH_ATTACK;
								main_tmr_q <= shadow_tmr_q;
							end
						end
						PH_PRERELEASE: begin
							if (shadow_amp_q < main_amp_q) begin
								phase_q <= PH_RELEASE;
								main_tmr_q <= shadow_tmr_q;
								main_amp_q <= shadow_amp_q;
							end
						end
						PH_RELEASE: begin
							if (note_q != NOTE_OFF) begin
								shadow_tmr_q <= 16'd0;
								shadow_amp_q <= 8'd0;
								phase_q <= PH_POSTRELEASE;
							end
						end
						default: ;
					endcase
				end
				ST_PUSH: begin
					if (!out_valid_q || env.ready) begin
						out_valid_q <= 1'b1;
						out_amp_q <= main_amp_q;
						out_phase_q <= phase_q;
						state_q <= ST_READY;
					end
				end
				default: state_q <= ST_READY;
			endcase
		end
	end

	assign cmd.ready = (state_q == ST_READY);
	assign env.valid = out_valid_q;
	assign env.amplitude = out_amp_q;
	assign env.phase = out_phase_q;
	assign ccmd = ccmd_q;

endmodule
`default_nettype wire

// ===== hw/rtl/adsr_envelope_generator_core.sv =====
// ADSR envelope generator with attack hold and shadow-curve crossfades.
// cmd channel: one transaction per item (operation: tick, note on, note off;
// elapsed_ms for ticks). env channel: one transaction per item with the
// amplitude and phase after that item, in input order.
// Registers sit on the APB port at byte address 4*i; write them only while idle.
// A tick runs up to two curve evaluations on the single curve unit, with
// its serial divider, normalize shifter, squaring loop and two
// root-product loops.
// One item is in work at a time; the next one is taken as soon as its
// result has been moved to the output register.
// If env is stalled, the finished result waits in the output register and
// the next item may still be taken and computed; its result then waits
// until the register frees.
// Reset clears the registers, the envelope to idle with zero amplitude,
// both timers and the note flag; no output is valid after reset.
`default_nettype none
module adsr_envelope_generator_core
	import adsr_pkg::*;
#(
	parameter int unsigned CURVE_TABLE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	adsr_in_if.sink          cmd,
	adsr_out_if.source       env,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [2:0] REG_ATTACK_SETTING  = 3'd0;
	localparam logic [2:0] REG_ATTACK_POWER    = 3'd1;
	localparam logic [2:0] REG_DECAY_SETTING   = 3'd2;
	localparam logic [2:0] REG_DECAY_POWER     = 3'd3;
	localparam logic [2:0] REG_SUSTAIN_LEVEL   = 3'd4;
	localparam logic [2:0] REG_RELEASE_SETTING = 3'd5;
	localparam logic [2:0] REG_RELEASE_POWER   = 3'd6;
	localparam logic [2:0] REG_HOLD_SETTING    = 3'd7;

	adsr_cfg_t  cfg_q;
	curve_cmd_t ccmd;
	curve_sts_t csts;
	logic [7:0] rd_byte;

	assign pready = 1'b1;

	// Take the write in the access phase; address bits below the word are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_ATTACK_SETTING: cfg_q.attack_setting <= pwdata[7:0];
				REG_ATTACK_POWER: cfg_q.attack_power <= pwdata[7:0];
				REG_DECAY_SETTING: cfg_q.decay_setting <= pwdata[7:0];
				REG_DECAY_POWER: cfg_q.decay_power <= pwdata[7:0];
				REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= pwdata[7:0];
				REG_RELEASE_SETTING: cfg_q.release_setting <= pwdata[7:0];
				REG_RELEASE_POWER: cfg_q.release_power <= pwdata[7:0];
				REG_HOLD_SETTING: cfg_q.hold_setting <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ATTACK_SETTING: rd_byte = cfg_q.attack_setting;
			REG_ATTACK_POWER: rd_byte = cfg_q.attack_power;
			REG_DECAY_SETTING: rd_byte = cfg_q.decay_setting;
			REG_DECAY_POWER: rd_byte = cfg_q.decay_power;
			REG_SUSTAIN_LEVEL: rd_byte = cfg_q.sustain_level;
			REG_RELEASE_SETTING: rd_byte = cfg_q.release_setting;
			REG_RELEASE_POWER: rd_byte = cfg_q.release_power;
			REG_HOLD_SETTING: rd_byte = cfg_q.hold_setting;
			default: rd_byte = 8'd0;
		endcase
	end

	assign prdata = {24'd0, rd_byte};

	// Phase sequencing, timers, amplitudes and the channel handshakes.
	adsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.env    (env),
		.ccmd   (ccmd),
		.csts   (csts)
	);

	// Serial evaluation of one curve point per request.
	adsr_curve #(
		.TBITS (CURVE_TABLE_BITS)
	) u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (ccmd),
		.sts    (csts)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/adsr_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module adsr_checker
	import adsr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       env_valid,
	input wire logic       env_ready,
	input wire logic [7:0] env_amplitude,
	input wire logic [3:0] env_phase
);

	// a stalled result stays offered
	`ASSERT_NEXT(a_env_hold, clk, arst_n, env_valid && !env_ready, env_valid)
	// one item in work at a time
	`ASSERT_NEXT(a_one_item, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	// the envelope never sounds before the first note starts
	`ASSERT_IMPLIES(a_idle_silent, clk, arst_n, env_valid && env_phase == PH_IDLE, env_amplitude == 8'd0)
	// hold is only entered at full scale and keeps it
	`ASSERT_IMPLIES(a_hold_peak, clk, arst_n, env_valid && env_phase == PH_HOLD, env_amplitude == 8'd255)

endmodule

bind adsr_envelope_generator_core adsr_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.env_valid     (env.valid),
	.env_ready     (env.ready),
	.env_amplitude (env.amplitude),
	.env_phase     (env.phase)
);
`default_nettype wire
